// ===== rtl/fmfc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fmfc_pkg
// Types and constants shared by the fnum/block frequency converter.
// ----------------------------------------------------------------------------
package fmfc_pkg;

    localparam int FACTOR_W  = 17;
    localparam int DEN_W     = 27;   // factor * 1000
    localparam int MHZ_W     = 23;   // in-range millihertz input
    localparam int PROD_W    = 37;   // den * fnum
    localparam int REM_W     = 45;   // 2*num + den
    localparam int DVS_W     = 28;   // 2*den
    localparam int FNUM_W    = 10;
    localparam int BLOCK_W   = 3;
    localparam int MHZ_OUT_W = 24;
    localparam int SHIFT_W   = 5;

    // quotient bit positions: bit 10 only flags overflow
    localparam int OVF_BIT   = 10;
    localparam int DIV_STAGES = 6;

    localparam logic               CMD_TO_MHZ  = 1'b0;
    localparam logic               CMD_TO_FNUM = 1'b1;

    localparam logic [FACTOR_W-1:0] FACTOR_RESET = 17'd49716;
    localparam logic [31:0]         MHZ_CEILING  = 32'd6208431;
    localparam logic [FNUM_W-1:0]   FNUM_MAX     = 10'd1023;
    localparam logic [BLOCK_W-1:0]  BLOCK_MAX    = 3'd7;
    localparam logic [SHIFT_W-1:0]  BASE_SHIFT   = 5'd20;

    localparam logic [31:0] LADDER [7] = '{
        32'd48503, 32'd97006, 32'd194013, 32'd388026,
        32'd776053, 32'd1552107, 32'd3104215
    };

    typedef struct packed {
        logic               cmd;
        logic               is_zero;
        logic               is_ceil;
        logic [BLOCK_W-1:0] blk;
        logic [PROD_W-1:0]  prod;
        logic [REM_W-1:0]   rem;
        logic [DVS_W-1:0]   dvs;
        logic [FNUM_W-1:0]  quo;
        logic               ovf;
    } pipe_t;

    // one restoring division step at quotient bit k
    function automatic pipe_t div_step(pipe_t p, int k);
        logic [REM_W-1:0] cand;
        pipe_t            r;
        cand = REM_W'(p.dvs) << k;
        r    = p;
        if (k == OVF_BIT) begin
            r.ovf = (p.rem >= cand);
        end else if (p.rem >= cand) begin
            r.rem = p.rem - cand;
            r.quo = p.quo | (FNUM_W'(1) << k);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/fmfc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fmfc_front
// Two pipeline stages: block ladder, denominator and range checks, then the
// forward product and the reverse dividend.
// ----------------------------------------------------------------------------
module fmfc_front
    import fmfc_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic [FACTOR_W-1:0] factor,
    input  wire logic                in_valid,
    output      logic                in_ready,
    input  wire logic                in_cmd,
    input  wire logic [31:0]         in_mhz,
    input  wire logic [FNUM_W-1:0]   in_fnum,
    input  wire logic [BLOCK_W-1:0]  in_block,
    output      logic                out_valid,
    input  wire logic                out_ready,
    output      pipe_t               out_data
);

    typedef struct packed {
        logic               cmd;
        logic               is_zero;
        logic               is_ceil;
        logic [BLOCK_W-1:0] blk;
        logic [MHZ_W-1:0]   mhz;
        logic [DEN_W-1:0]   den;
        logic [FNUM_W-1:0]  fnum;
    } front_t;

    logic   a_valid_reg;
    front_t a_reg, a_next;
    logic   a_ready;
    logic   b_valid_reg;
    pipe_t  b_reg, b_next;
    logic   b_ready;

    assign b_ready   = !b_valid_reg || out_ready;
    assign a_ready   = !a_valid_reg || b_ready;
    assign in_ready  = a_ready;
    assign out_valid = b_valid_reg;
    assign out_data  = b_reg;

    always_comb begin
        logic [BLOCK_W-1:0] ladder_blk;
        ladder_blk = '0;
        for (int i = 0; i < 7; i++) begin
            ladder_blk = ladder_blk + BLOCK_W'(in_mhz > LADDER[i]);
        end
        a_next.cmd     = in_cmd;
        a_next.is_zero = (in_mhz == '0);
        a_next.is_ceil = (in_mhz > MHZ_CEILING);
        a_next.blk     = (in_cmd == CMD_TO_MHZ) ? in_block : ladder_blk;
        a_next.mhz     = in_mhz[MHZ_W-1:0];
        // factor * 1000 = factor * (1024 - 16 - 8)
        a_next.den     = (DEN_W'(factor) << 10) - (DEN_W'(factor) << 4)
                         - (DEN_W'(factor) << 3);
        a_next.fnum    = in_fnum;
    end

    always_comb begin
        logic [SHIFT_W-1:0] sh;
        sh            = BASE_SHIFT - SHIFT_W'(a_reg.blk);
        b_next.cmd     = a_reg.cmd;
        b_next.is_zero = a_reg.is_zero;
        b_next.is_ceil = a_reg.is_ceil;
        b_next.blk     = a_reg.blk;
        b_next.prod    = PROD_W'(a_reg.den) * PROD_W'(a_reg.fnum);
        b_next.rem     = (REM_W'({a_reg.mhz, 1'b0}) << sh) + REM_W'(a_reg.den);
        b_next.dvs     = {a_reg.den, 1'b0};
        b_next.quo     = '0;
        b_next.ovf     = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (a_ready) a_valid_reg <= in_valid;
            if (b_ready) b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && a_ready) a_reg <= a_next;
        if (a_valid_reg && b_ready) b_reg <= b_next;
    end

endmodule
`default_nettype wire

// ===== rtl/fmfc_div_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fmfc_div_stage
// One registered stage of the restoring divider, two quotient bits a stage (one when FIRST_BIT is 0).
// ----------------------------------------------------------------------------
module fmfc_div_stage
    import fmfc_pkg::*;
#(
    parameter int FIRST_BIT = 10
)(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  in_valid,
    output      logic  in_ready,
    input  wire pipe_t in_data,
    output      logic  out_valid,
    input  wire logic  out_ready,
    output      pipe_t out_data
);

    logic  valid_reg;
    pipe_t data_reg, data_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        data_next = div_step(in_data, FIRST_BIT);
        if (FIRST_BIT > 0) data_next = div_step(data_next, FIRST_BIT - 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) data_reg <= data_next;
    end

endmodule
`default_nettype wire

// ===== rtl/fmfc_out.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fmfc_out
// Result selection and output register.
// ----------------------------------------------------------------------------
module fmfc_out
    import fmfc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output      logic                 in_ready,
    input  wire pipe_t                in_data,
    output      logic                 out_valid,
    input  wire logic                 out_ready,
    output      logic [MHZ_OUT_W-1:0] out_mhz,
    output      logic [FNUM_W-1:0]    out_fnum,
    output      logic [BLOCK_W-1:0]   out_block,
    output      logic                 out_clipped
);

    logic                 valid_reg;
    logic [MHZ_OUT_W-1:0] mhz_reg, mhz_next;
    logic [FNUM_W-1:0]    fnum_reg, fnum_next;
    logic [BLOCK_W-1:0]   block_reg, block_next;
    logic                 clip_reg, clip_next;

    assign in_ready    = !valid_reg || out_ready;
    assign out_valid   = valid_reg;
    assign out_mhz     = mhz_reg;
    assign out_fnum    = fnum_reg;
    assign out_block   = block_reg;
    assign out_clipped = clip_reg;

    always_comb begin
        logic [SHIFT_W-1:0] sh;
        logic [PROD_W-1:0]  shifted;
        sh         = BASE_SHIFT - SHIFT_W'(in_data.blk);
        shifted    = in_data.prod >> sh;
        mhz_next   = '0;
        fnum_next  = '0;
        block_next = '0;
        clip_next  = 1'b0;
        if (in_data.cmd == CMD_TO_MHZ) begin
            mhz_next = shifted[MHZ_OUT_W-1:0];
        end else if (in_data.is_zero) begin
            // zero input stays zero, even with a zero factor
        end else if (in_data.is_ceil) begin
            fnum_next  = FNUM_MAX;
            block_next = BLOCK_MAX;
            clip_next  = 1'b1;
        end else if (in_data.ovf) begin
            // also covers a zero factor: divisor zero always overflows
            fnum_next  = FNUM_MAX;
            block_next = in_data.blk;
            clip_next  = 1'b1;
        end else begin
            fnum_next  = in_data.quo;
            block_next = in_data.blk;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            mhz_reg   <= mhz_next;
            fnum_reg  <= fnum_next;
            block_reg <= block_next;
            clip_reg  <= clip_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/fm_block_fnum_frequency_converter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fm_block_fnum_frequency_converter
// Converts between millihertz and FM fnum/octave block in either direction.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one conversion request a beat; s_tuser selects the direction
//   (0 = fnum/block to millihertz, 1 = millihertz to fnum/block).
//   m_ channel: one result beat per request, in request order; m_tuser is
//   the clipped flag.
//   cfg_ channel: writes the 17-bit conversion factor; always ready. Write it
//   only while no request is in flight.
//   A request passes nine register stages, the first loaded at the accepting
//   edge - two front stages (ladder and denominator, then product and
//   dividend), six divider stages of two quotient bits each (the last holds
//   bit 0 only), and the output register. Throughput is one beat per cycle
//   while m_tready stays high; the divider pipeline sets this.
//   When the receiver stalls, beats compact into empty stages and s_tready
//   drops only once every stage holds a beat; nothing is lost or repeated.
//   Reset empties the pipeline and sets the factor back to 49716.
// ----------------------------------------------------------------------------
module fm_block_fnum_frequency_converter
    import fmfc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    // [31:0] milli_hertz_in, [41:32] fnum_in, [44:42] block_in, [47:45] zero
    input  wire logic [47:0] s_tdata,
    // [0] cmd
    input  wire logic        s_tuser,
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    // [23:0] milli_hertz_out, [33:24] fnum_out, [36:34] block_out, [39:37] zero
    output      logic [39:0] m_tdata,
    // [0] clipped
    output      logic        m_tuser,
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [16:0] cfg_data
);

    logic [FACTOR_W-1:0]  factor_reg;
    pipe_t                stage_data  [DIV_STAGES+1];
    logic                 stage_valid [DIV_STAGES+1];
    logic                 stage_ready [DIV_STAGES+1];
    logic [MHZ_OUT_W-1:0] res_mhz;
    logic [FNUM_W-1:0]    res_fnum;
    logic [BLOCK_W-1:0]   res_block;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            factor_reg <= FACTOR_RESET;
        end else if (cfg_valid) begin
            factor_reg <= cfg_data;
        end
    end

    fmfc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .factor    (factor_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tuser),
        .in_mhz    (s_tdata[31:0]),
        .in_fnum   (s_tdata[41:32]),
        .in_block  (s_tdata[44:42]),
        .out_valid (stage_valid[0]),
        .out_ready (stage_ready[0]),
        .out_data  (stage_data[0])
    );

    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
        fmfc_div_stage #(
            .FIRST_BIT (OVF_BIT - 2 * j)
        ) u_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stage_valid[j]),
            .in_ready  (stage_ready[j]),
            .in_data   (stage_data[j]),
            .out_valid (stage_valid[j+1]),
            .out_ready (stage_ready[j+1]),
            .out_data  (stage_data[j+1])
        );
    end

    fmfc_out u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (stage_valid[DIV_STAGES]),
        .in_ready    (stage_ready[DIV_STAGES]),
        .in_data     (stage_data[DIV_STAGES]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_mhz     (res_mhz),
        .out_fnum    (res_fnum),
        .out_block   (res_block),
        .out_clipped (m_tuser)
    );

    assign m_tdata = {3'b000, res_block, res_fnum, res_mhz};

endmodule
`default_nettype wire

// ===== tb/tb_fm_block_fnum_frequency_converter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fm_block_fnum_frequency_converter
// Checks both conversion directions against a local predictor.
// Covers directed corner frequencies, the octave ladder edges and both
// factor extremes. A long random run uses random gaps on both channels,
// and one long receiver hold-off stalls the input side.
// ----------------------------------------------------------------------------
module tb_fm_block_fnum_frequency_converter;

    localparam logic [31:0] MHZ_LIMIT   = 32'd6208431;
    localparam logic [9:0]  FNUM_TOP    = 10'd1023;
    localparam logic [16:0] FACTOR_DFLT = 17'd49716;
    localparam logic [16:0] FACTOR_MAX  = 17'd131071;
    localparam int          HOLD_CYCLES = 300;
    localparam int          STALL_LIMIT = 3000;
    localparam int          TAIL_CYCLES = 12;

    typedef struct packed {
        logic        cmd;
        logic [31:0] mhz;
        logic [9:0]  fnum;
        logic [2:0]  blk;
    } conv_req_t;

    typedef struct packed {
        logic [23:0] mhz;
        logic [9:0]  fnum;
        logic [2:0]  blk;
        logic        clip;
    } conv_res_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [16:0] cfg_data  = '0;

    conv_res_t   due_results[$];
    logic [16:0] factor_shadow = FACTOR_DFLT;
    logic        src_idle_en   = 1'b1;
    logic        sink_idle_en  = 1'b1;
    logic        hold_req      = 1'b0;
    int          hold_left     = 0;
    int          mismatches    = 0;
    int          stall_cnt     = 0;
    conv_res_t   got, want;

    fm_block_fnum_frequency_converter u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #4 aclk = ~aclk;

    function automatic logic [31:0] octave_edge(input int idx);
        case (idx)
            0:       return 32'd48503;
            1:       return 32'd97006;
            2:       return 32'd194013;
            3:       return 32'd388026;
            4:       return 32'd776053;
            5:       return 32'd1552107;
            default: return 32'd3104215;
        endcase
    endfunction

    function automatic conv_res_t predict_conversion(input conv_req_t req,
                                                     input logic [16:0] factor);
        conv_res_t   r;
        logic [63:0] prod, num, den, quo;
        int          b;
        r = '0;
        if (req.cmd == fmfc_pkg::CMD_TO_MHZ) begin
            prod  = 64'd1000 * 64'(factor) * 64'(req.fnum);
            prod  = prod >> (20 - int'(req.blk));
            r.mhz = prod[23:0];
        end else if (req.mhz == 32'd0) begin
            r = '0;
        end else if (req.mhz > MHZ_LIMIT) begin
            r.fnum = FNUM_TOP;
            r.blk  = 3'd7;
            r.clip = 1'b1;
        end else begin
            b = 0;
            for (int i = 0; i < 7; i++) begin
                if (req.mhz > octave_edge(i)) b = i + 1;
            end
            r.blk = b[2:0];
            den   = 64'(factor) * 64'd1000;
            if (den == 64'd0) begin
                r.fnum = FNUM_TOP;
                r.clip = 1'b1;
            end else begin
                num = 64'(req.mhz) << (20 - b);
                // round half up
                quo = (64'd2 * num + den) / (64'd2 * den);
                if (quo > 64'(FNUM_TOP)) begin
                    r.fnum = FNUM_TOP;
                    r.clip = 1'b1;
                end else begin
                    r.fnum = quo[9:0];
                end
            end
        end
        return r;
    endfunction

    function automatic conv_req_t mk_req(input logic cmd, input logic [31:0] mhz,
                                         input logic [9:0] fnum, input logic [2:0] blk);
        conv_req_t r;
        r.cmd  = cmd;
        r.mhz  = mhz;
        r.fnum = fnum;
        r.blk  = blk;
        return r;
    endfunction

    function automatic conv_req_t rand_req();
        conv_req_t r;
        r.cmd  = 1'($urandom_range(0, 1));
        r.fnum = 10'($urandom_range(0, 1023));
        r.blk  = 3'($urandom_range(0, 7));
        case ($urandom_range(0, 9))
            0:       r.mhz = $urandom();
            1:       r.mhz = MHZ_LIMIT - 32'd3 + 32'($urandom_range(0, 6));
            2, 3:    r.mhz = octave_edge($urandom_range(0, 6)) - 32'd2
                             + 32'($urandom_range(0, 4));
            4:       r.mhz = 32'($urandom_range(0, 1000));
            default: r.mhz = 32'($urandom_range(1, MHZ_LIMIT));
        endcase
        if (r.cmd == fmfc_pkg::CMD_TO_MHZ && $urandom_range(0, 7) == 0) begin
            r.fnum = ($urandom_range(0, 1) != 0) ? FNUM_TOP : 10'd0;
        end
        return r;
    endfunction

    // one beat on the request channel; expectation queued on acceptance
    task automatic send_conv(input conv_req_t req);
        if (src_idle_en) begin
            while ($urandom_range(0, 99) < 25) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, req.blk, req.fnum, req.mhz};
        s_tuser  <= req.cmd;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        due_results.insert(due_results.size(), predict_conversion(req, factor_shadow));
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++) send_conv(rand_req());
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
    endtask

    // only called with nothing in flight
    task automatic write_factor(input logic [16:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid     <= 1'b0;
        factor_shadow  = value;
    endtask

    task automatic test_directed();
        send_conv(mk_req(fmfc_pkg::CMD_TO_MHZ, 32'hFFFFFFFF, 10'd0, 3'd0));
        send_conv(mk_req(fmfc_pkg::CMD_TO_MHZ, 32'd0, FNUM_TOP, 3'd7));
        send_conv(mk_req(fmfc_pkg::CMD_TO_MHZ, 32'd0, FNUM_TOP, 3'd0));
        send_conv(mk_req(fmfc_pkg::CMD_TO_MHZ, 32'd0, 10'd1, 3'd7));
        send_conv(mk_req(fmfc_pkg::CMD_TO_MHZ, 32'd0, 10'h2AA, 3'd5));
        send_conv(mk_req(fmfc_pkg::CMD_TO_MHZ, 32'd0, 10'h155, 3'd2));
        send_conv(mk_req(fmfc_pkg::CMD_TO_FNUM, 32'd0, FNUM_TOP, 3'd7));
        send_conv(mk_req(fmfc_pkg::CMD_TO_FNUM, 32'd1, 10'd0, 3'd0));
        send_conv(mk_req(fmfc_pkg::CMD_TO_FNUM, 32'd48503, 10'd0, 3'd0));
        send_conv(mk_req(fmfc_pkg::CMD_TO_FNUM, 32'd48504, 10'd0, 3'd0));
        send_conv(mk_req(fmfc_pkg::CMD_TO_FNUM, 32'd97006, 10'd0, 3'd0));
        send_conv(mk_req(fmfc_pkg::CMD_TO_FNUM, 32'd97007, 10'd0, 3'd0));
        send_conv(mk_req(fmfc_pkg::CMD_TO_FNUM, 32'd3104215, 10'd0, 3'd0));
        send_conv(mk_req(fmfc_pkg::CMD_TO_FNUM, 32'd3104216, 10'd0, 3'd0));
        send_conv(mk_req(fmfc_pkg::CMD_TO_FNUM, MHZ_LIMIT, 10'd0, 3'd0));
        send_conv(mk_req(fmfc_pkg::CMD_TO_FNUM, MHZ_LIMIT + 32'd1, 10'd0, 3'd0));
        send_conv(mk_req(fmfc_pkg::CMD_TO_FNUM, 32'hFFFFFFFF, FNUM_TOP, 3'd7));
        send_conv(mk_req(fmfc_pkg::CMD_TO_FNUM, 32'hAAAAAAAA, 10'h155, 3'd5));
        send_conv(mk_req(fmfc_pkg::CMD_TO_FNUM, 32'h55555555, 10'h2AA, 3'd2));
        drain();
    endtask

    // tiny factor clips almost everything, huge one gives small fnums
    task automatic test_factor_extremes();
        write_factor(17'd1);
        send_conv(mk_req(fmfc_pkg::CMD_TO_FNUM, 32'd1, 10'd0, 3'd0));
        send_conv(mk_req(fmfc_pkg::CMD_TO_MHZ, 32'd0, FNUM_TOP, 3'd7));
        send_random(120);
        drain();
        write_factor(FACTOR_MAX);
        send_conv(mk_req(fmfc_pkg::CMD_TO_MHZ, 32'd0, FNUM_TOP, 3'd7));
        send_conv(mk_req(fmfc_pkg::CMD_TO_FNUM, MHZ_LIMIT, 10'd0, 3'd0));
        send_random(120);
        drain();
    endtask

    task automatic test_random_factors();
        for (int p = 0; p < 4; p++) begin
            write_factor(17'($urandom_range(1, FACTOR_MAX)));
            send_random(120);
            drain();
        end
    endtask

    task automatic test_no_idle();
        write_factor(FACTOR_DFLT);
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        send_random(200);
        drain();
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    // receiver holds off while the sender keeps offering beats
    task automatic test_backpressure();
        write_factor(17'($urandom_range(1, FACTOR_MAX)));
        src_idle_en = 1'b0;
        hold_req    = 1'b1;
        send_random(80);
        drain();
        src_idle_en = 1'b1;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = {m_tdata[23:0], m_tdata[33:24], m_tdata[36:34], m_tuser};
                if (due_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result beat %h clip %b",
                                 $realtime, m_tdata, m_tuser);
                end else begin
                    want = due_results.pop_front();
                    if (got.mhz !== want.mhz || got.fnum !== want.fnum ||
                        got.blk !== want.blk || got.clip !== want.clip) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $write("%0t: exp mhz %0d fnum %0d blk %0d clip %0d, ",
                                   $realtime, want.mhz, want.fnum, want.blk,
                                   want.clip);
                            $display("got mhz %0d fnum %0d blk %0d clip %0d",
                                     got.mhz, got.fnum, got.blk, got.clip);
                        end
                    end
                end
            end
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_tready <= 1'b0;
            end else if (sink_idle_en) begin
                m_tready <= ($urandom_range(0, 99) >= 25);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready)) begin
                stall_cnt = 0;
            end else begin
                stall_cnt = stall_cnt + 1;
            end
            if (stall_cnt >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_factor_extremes();
        test_random_factors();
        test_no_idle();
        test_backpressure();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && due_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
